FILE: sv/psht_pkg.sv
// shared types and codes for the puzzle state hash table
// no dependencies
package psht_pkg;

  localparam int KEY_W   = 27;
  localparam int CELL_W  = 4;
  localparam int NCELL   = 9;
  localparam int CELLS_W = CELL_W * NCELL;
  localparam int OP_W    = 2;
  localparam int ST_W    = 2;
  localparam int IN_DW   = 64;
  localparam int OUT_DW  = 72;

  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_SEARCH   = 2'd1;
  localparam logic [OP_W-1:0] OP_RETRIEVE = 2'd2;
  localparam logic [OP_W-1:0] OP_CLEAR    = 2'd3;

  localparam logic [ST_W-1:0] ST_OK   = 2'd0;
  localparam logic [ST_W-1:0] ST_MISS = 2'd1;
  localparam logic [ST_W-1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [KEY_W-1:0]   key;
    logic [CELLS_W-1:0] cells;
  } cmd_t;

endpackage

FILE: sv/psht_front.sv
// front end: accepts beats, forms the decimal key (retrieve takes it from the beat) and its bucket
// depends on psht_pkg
module psht_front #(
  parameter int BUCKETS = 1000
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [psht_pkg::IN_DW-1:0]    in_tdata,
  input  logic [psht_pkg::OP_W-1:0]     in_tuser,
  input  logic                          init_done,
  output logic                          q_valid,
  input  logic                          q_ready,
  output psht_pkg::cmd_t                q_cmd,
  output logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] q_bucket
);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int RW = BW + 1;
  localparam int KW = psht_pkg::KEY_W;
  localparam int SW = KW + 1;

  typedef enum logic [1:0] {F_IDLE, F_KEY, F_MOD, F_PUSH} fstate_t;

  fstate_t                      state_r;
  logic [psht_pkg::OP_W-1:0]    op_r;
  logic [psht_pkg::CELLS_W-1:0] cells_r;
  logic [KW-1:0]                key_r;
  logic [SW-1:0]                sh_r;
  logic [RW-1:0]                rem_r;
  logic [BW-1:0]                bkt_r;
  logic [2:0]                   cnt_r;
  logic [KW-1:0]                key_nxt;
  logic [RW-1:0]                rem_nxt;

  always_comb begin
    logic [2:0] di;
    key_nxt = key_r;
    for (int j = 0; j < 4; j++) begin
      di = {cnt_r[0], 2'(j)};
      key_nxt = (key_nxt << 3) + (key_nxt << 1)
                + KW'(cells_r[psht_pkg::CELL_W*di +: psht_pkg::CELL_W]);
    end
  end

  always_comb begin
    rem_nxt = rem_r;
    for (int j = 0; j < 4; j++) begin
      rem_nxt = {rem_nxt[RW-2:0], sh_r[SW-1-j]};
      if (rem_nxt >= RW'(BUCKETS)) begin
        rem_nxt = rem_nxt - RW'(BUCKETS);
      end
    end
  end

  assign in_tready = (state_r == F_IDLE) && init_done;
  assign q_valid   = (state_r == F_PUSH);
  assign q_cmd     = '{op: op_r, key: key_r, cells: cells_r};
  assign q_bucket  = bkt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      cnt_r   <= '0;
    end else begin
      case (state_r)
        F_IDLE: begin
          if (in_tvalid && in_tready) begin
            op_r    <= in_tuser;
            cells_r <= in_tdata[psht_pkg::CELLS_W-1:0];
            cnt_r   <= '0;
            rem_r   <= '0;
            bkt_r   <= '0;
            case (in_tuser)
              psht_pkg::OP_RETRIEVE: begin
                key_r   <= in_tdata[psht_pkg::CELLS_W +: KW];
                sh_r    <= {1'b0, in_tdata[psht_pkg::CELLS_W +: KW]};
                state_r <= F_MOD;
              end
              psht_pkg::OP_CLEAR: begin
                key_r   <= '0;
                state_r <= F_PUSH;
              end
              default: begin
                key_r   <= '0;
                state_r <= F_KEY;
              end
            endcase
          end
        end
        F_KEY: begin
          key_r <= key_nxt;
          if (cnt_r[0]) begin
            sh_r    <= {1'b0, key_nxt};
            cnt_r   <= '0;
            state_r <= F_MOD;
          end else begin
            cnt_r <= cnt_r + 3'd1;
          end
        end
        F_MOD: begin
          rem_r <= rem_nxt;
          sh_r  <= sh_r << 4;
          cnt_r <= cnt_r + 3'd1;
          if (cnt_r == 3'd6) begin
            bkt_r   <= rem_nxt[BW-1:0];
            state_r <= F_PUSH;
          end
        end
        F_PUSH: begin
          if (q_ready) begin
            state_r <= F_IDLE;
          end
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/psht_queue.sv
// two-entry command queue between front and back
// no dependencies
module psht_queue #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          s_valid,
  output logic          s_ready,
  input  logic [DW-1:0] s_data,
  output logic          m_valid,
  input  logic          m_ready,
  output logic [DW-1:0] m_data
);
  logic [DW-1:0] mem_r [2];
  logic          wp_r;
  logic          rp_r;
  logic [1:0]    cnt_r;
  logic          push;
  logic          pop;

  assign s_ready = (cnt_r != 2'd2);
  assign m_valid = (cnt_r != 2'd0);
  assign m_data  = mem_r[rp_r];
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= s_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
  end

endmodule

FILE: sv/psht_back.sv
// back end: bucket heads, node pool, chain walk and result register
// depends on psht_pkg
module psht_back #(
  parameter int BUCKETS    = 1000,
  parameter int POOL_NODES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        q_valid,
  output logic                        q_ready,
  input  psht_pkg::cmd_t              q_cmd,
  input  logic [((BUCKETS > 1) ? $clog2(BUCKETS) : 1)-1:0] q_bucket,
  output logic                        init_done,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [psht_pkg::OUT_DW-1:0] out_tdata
);
  localparam int BW  = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NIW = $clog2(POOL_NODES);
  localparam int NRW = $clog2(POOL_NODES + 1);
  localparam int KW  = psht_pkg::KEY_W;
  localparam int CW  = psht_pkg::CELLS_W;
  localparam int PAD = psht_pkg::OUT_DW - psht_pkg::ST_W - KW - CW;

  typedef enum logic [2:0] {S_CLR, S_IDLE, S_HEAD, S_NODE, S_RESP} bstate_t;

  logic [NRW-1:0] chain_head [BUCKETS];
  logic [KW-1:0]  node_key   [POOL_NODES];
  logic [CW-1:0]  node_cells [POOL_NODES];
  logic [NRW-1:0] node_link  [POOL_NODES];

  bstate_t                   state_r;
  psht_pkg::cmd_t            cur_r;
  logic [BW-1:0]             bkt_r;
  logic [NRW-1:0]            pool_r;
  logic [BW-1:0]             clr_r;
  logic                      init_r;
  logic                      out_valid_r;
  logic [psht_pkg::OUT_DW-1:0] out_data_r;
  logic [psht_pkg::ST_W-1:0] res_st_r;
  logic [KW-1:0]             res_key_r;
  logic [CW-1:0]             res_cells_r;

  logic [NRW-1:0] head_q;
  logic [KW-1:0]  nk_q;
  logic [CW-1:0]  nc_q;
  logic [NRW-1:0] nl_q;

  logic           head_we;
  logic [BW-1:0]  head_waddr;
  logic [NRW-1:0] head_wdata;
  logic           node_we;
  logic [NRW-1:0] nref;
  logic [NIW-1:0] node_raddr;
  logic           hit;

  assign q_ready    = (state_r == S_IDLE);
  assign init_done  = init_r;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  assign nref       = (state_r == S_HEAD) ? head_q : nl_q;
  assign node_raddr = NIW'(nref - NRW'(1));
  assign hit        = (nk_q == cur_r.key);

  always_comb begin
    head_we    = 1'b0;
    head_waddr = bkt_r;
    head_wdata = '0;
    node_we    = 1'b0;
    case (state_r)
      S_CLR: begin
        head_we    = 1'b1;
        head_waddr = clr_r;
      end
      S_HEAD: begin
        if (cur_r.op == psht_pkg::OP_INSERT) begin
          head_we    = 1'b1;
          head_wdata = pool_r + NRW'(1);
          node_we    = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (head_we) begin
      chain_head[head_waddr] <= head_wdata;
    end
    head_q <= chain_head[q_bucket];
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_key[pool_r[NIW-1:0]]   <= cur_r.key;
      node_cells[pool_r[NIW-1:0]] <= cur_r.cells;
      node_link[pool_r[NIW-1:0]]  <= head_q;
    end
    nk_q <= node_key[node_raddr];
    nc_q <= node_cells[node_raddr];
    nl_q <= node_link[node_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      pool_r      <= '0;
      init_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_RESP && (!out_valid_r || out_tready)) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLR: begin
          if (clr_r == BW'(BUCKETS - 1)) begin
            clr_r  <= '0;
            pool_r <= '0;
            if (init_r) begin
              res_st_r    <= psht_pkg::ST_OK;
              res_key_r   <= '0;
              res_cells_r <= '0;
              state_r     <= S_RESP;
            end else begin
              init_r  <= 1'b1;
              state_r <= S_IDLE;
            end
          end else begin
            clr_r <= clr_r + BW'(1);
          end
        end
        S_IDLE: begin
          if (q_valid) begin
            cur_r <= q_cmd;
            bkt_r <= q_bucket;
            if (q_cmd.op == psht_pkg::OP_CLEAR) begin
              state_r <= S_CLR;
            end else if (q_cmd.op == psht_pkg::OP_INSERT
                         && pool_r >= NRW'(POOL_NODES)) begin
              res_st_r    <= psht_pkg::ST_FULL;
              res_key_r   <= '0;
              res_cells_r <= '0;
              state_r     <= S_RESP;
            end else begin
              state_r <= S_HEAD;
            end
          end
        end
        S_HEAD: begin
          res_cells_r <= '0;
          if (cur_r.op == psht_pkg::OP_INSERT) begin
            pool_r    <= pool_r + NRW'(1);
            res_st_r  <= psht_pkg::ST_OK;
            res_key_r <= cur_r.key;
            state_r   <= S_RESP;
          end else if (head_q == '0) begin
            res_st_r  <= psht_pkg::ST_MISS;
            res_key_r <= '0;
            state_r   <= S_RESP;
          end else begin
            state_r <= S_NODE;
          end
        end
        S_NODE: begin
          if (hit) begin
            res_st_r  <= psht_pkg::ST_OK;
            res_key_r <= cur_r.key;
            if (cur_r.op == psht_pkg::OP_RETRIEVE) begin
              res_cells_r <= nc_q;
            end
            state_r <= S_RESP;
          end else if (nl_q == '0) begin
            res_st_r  <= psht_pkg::ST_MISS;
            res_key_r <= '0;
            state_r   <= S_RESP;
          end
        end
        S_RESP: begin
          if (!out_valid_r || out_tready) begin
            out_data_r <= {{PAD{1'b0}}, res_cells_r, res_key_r, res_st_r};
            state_r    <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: sv/puzzle_state_hash_table.sv
// path: front key (F_KEY, skipped for retrieve) and bucket (F_MOD) states, the queue, then
// the back end head read (S_HEAD), chain walk for search and retrieve (S_NODE) and S_RESP
// one request at a time in the back end; chain walk reads one node per cycle
// front takes a new beat only after its previous command has gone into the queue
// clear sweeps every bucket head in the back end and resets the node pool
// after rst_n the bucket heads are swept with in_tready low
module puzzle_state_hash_table #(
  parameter int BUCKETS    = 1000,
  parameter int POOL_NODES = 4096
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  // cell0..cell8 (4 bits each), lookup_key (27), zero pad
  input  logic [psht_pkg::IN_DW-1:0]  in_tdata,
  // op
  input  logic [psht_pkg::OP_W-1:0]   in_tuser,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  // status (2), key_out (27), out_cell0..out_cell8 (4 bits each), zero pad
  output logic [psht_pkg::OUT_DW-1:0] out_tdata
);
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int QW = $bits(psht_pkg::cmd_t) + BW;

  logic           init_done;
  logic           fq_valid;
  logic           fq_ready;
  psht_pkg::cmd_t fq_cmd;
  logic [BW-1:0]  fq_bucket;
  logic           qb_valid;
  logic           qb_ready;
  logic [QW-1:0]  qb_data;

  psht_front #(.BUCKETS(BUCKETS)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .init_done (init_done),
    .q_valid   (fq_valid),
    .q_ready   (fq_ready),
    .q_cmd     (fq_cmd),
    .q_bucket  (fq_bucket)
  );

  psht_queue #(.DW(QW)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (fq_valid),
    .s_ready (fq_ready),
    .s_data  ({fq_bucket, fq_cmd}),
    .m_valid (qb_valid),
    .m_ready (qb_ready),
    .m_data  (qb_data)
  );

  psht_back #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (qb_valid),
    .q_ready    (qb_ready),
    .q_cmd      (qb_data[$bits(psht_pkg::cmd_t)-1:0]),
    .q_bucket   (qb_data[QW-1 -: BW]),
    .init_done  (init_done),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

`ifndef SYNTHESIS
  a_no_accept_in_init: assert property (@(posedge clk) disable iff (!rst_n)
    !init_done |-> !in_tready) else $error("input taken during head sweep");

  a_miss_key_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == psht_pkg::ST_MISS |-> out_tdata[28:2] == '0)
    else $error("miss with nonzero key");

  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1:0] == psht_pkg::ST_FULL |-> out_tdata[64:2] == '0)
    else $error("pool full with nonzero payload");
`endif

endmodule
